// ===== src/pli_pkg.sv =====
// types and codes shared by the positional list block
`default_nettype none

package pli_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [4:0]  position;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [4:0]  entry_count;
    logic        [4:0]  entry_position;
    logic signed [31:0] entry_value;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_PREV,
    SEL_NEXT,
    SEL_HEAD
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t          sel;
    logic signed [31:0] load_value;
    logic signed [31:0] head_value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/pli_cell.sv =====
// one storage cell of the list chain
`default_nettype none

module pli_cell
  import pli_pkg::*;
(
  input  wire                      clk,
  input  wire cell_ctrl_t          ctrl,
  input  wire logic signed [31:0]  prev_value,
  input  wire logic signed [31:0]  next_value,
  output logic signed [31:0]       value
);

  logic signed [31:0] value_next;

  always_comb begin
    unique case (ctrl.sel)
      SEL_HOLD: value_next = value;
      SEL_LOAD: value_next = ctrl.load_value;
      SEL_PREV: value_next = prev_value;
      SEL_NEXT: value_next = next_value;
      SEL_HEAD: value_next = ctrl.head_value;
      default:  value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ===== src/positional_list_insert_delete.sv =====
// positional list: ordered store of signed values with insert, delete and dump
//
// channels: cmd (valid/ready, cmd_t) carries one operation per beat; res
// (valid/ready, res_t) returns the results. insert and delete give one
// result beat, marked last; a dump gives one beat per stored entry, in
// order, the final one marked last, or a single empty-status beat.
// timing: an insert, delete or empty-dump result is registered at the edge that
// takes its cmd beat; the first entry beat of a dump is loaded in the cycle after.
// insert and delete shift the cells from the given position onward in the
// cycle that takes the cmd beat. during a dump the chain rotates its first
// count cells one step per result beat and is back in order after the final one.
// a new cmd beat is taken while a result waits, once the output register
// frees up that cycle; during a dump no cmd beat is taken.
// reset clears the entry count, the dump sequencer and res_valid; the
// stored values are not cleared. when res_ready is low the output register
// holds its beat and the dump sequencer waits.
`default_nettype none

module positional_list_insert_delete
  import pli_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire       res_ready,
  output res_t      res
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  dump_idx;
  logic           dumping;
  logic           slot_free;
  logic           accept;
  logic           dump_step;
  logic           dump_last;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;
  logic           ins_range_ok;
  logic           ins_ok;
  logic           ins_full;
  logic           del_ok;
  logic           do_ins;
  logic           do_del;
  logic           res_load;
  res_t           res_next;

  logic signed [31:0] vals [DEPTH];
  cell_ctrl_t         ctrls [DEPTH];

  assign slot_free = !res_valid || res_ready;
  assign cmd_ready = !dumping && slot_free;
  assign accept    = cmd_valid && cmd_ready;
  assign dump_step = dumping && slot_free;
  assign dump_last = (dump_idx + CW'(1)) == count;

  assign pos_w = CMPW'(cmd.position);
  assign cnt_w = CMPW'(count);

  assign ins_range_ok = (pos_w != '0) && (pos_w <= cnt_w + CMPW'(1));
  assign ins_full     = cnt_w == CMPW'(DEPTH);
  assign ins_ok       = ins_range_ok && !ins_full;
  assign del_ok       = (pos_w != '0) && (pos_w <= cnt_w);
  assign do_ins       = accept && (cmd.kind == KIND_INSERT) && ins_ok;
  assign do_del       = accept && (cmd.kind == KIND_DELETE) && del_ok;

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrls[i].sel        = SEL_HOLD;
      ctrls[i].load_value = cmd.value;
      ctrls[i].head_value = vals[0];
      if (do_ins) begin
        if (CMPW'(i) + CMPW'(1) == pos_w) begin
          ctrls[i].sel = SEL_LOAD;
        end else if (CMPW'(i) + CMPW'(1) > pos_w) begin
          ctrls[i].sel = SEL_PREV;
        end
      end else if (do_del) begin
        if (CMPW'(i) + CMPW'(1) >= pos_w) begin
          ctrls[i].sel = SEL_NEXT;
        end
      end else if (dump_step) begin
        if (CMPW'(i) + CMPW'(1) < cnt_w) begin
          ctrls[i].sel = SEL_NEXT;
        end else if (CMPW'(i) + CMPW'(1) == cnt_w) begin
          ctrls[i].sel = SEL_HEAD;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] prev_v;
    logic signed [31:0] next_v;
    if (g == 0) begin : g_first
      assign prev_v = vals[g];
    end else begin : g_mid_prev
      assign prev_v = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_final
      assign next_v = vals[g];
    end else begin : g_mid_next
      assign next_v = vals[g+1];
    end
    pli_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrls[g]),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (vals[g])
    );
  end

  // result and count
  always_comb begin
    count_next              = count;
    res_load                = 1'b0;
    res_next.status         = ST_OK;
    res_next.entry_count    = 5'(count);
    res_next.entry_position = '0;
    res_next.entry_value    = '0;
    res_next.last           = 1'b1;
    if (dump_step) begin
      res_load                = 1'b1;
      res_next.entry_position = 5'(dump_idx + CW'(1));
      res_next.entry_value    = vals[0];
      res_next.last           = dump_last;
    end else if (accept) begin
      unique case (cmd.kind)
        KIND_INSERT: begin
          res_load = 1'b1;
          if (!ins_range_ok) begin
            res_next.status = ST_RANGE;
          end else if (ins_full) begin
            res_next.status = ST_FULL;
          end else begin
            count_next = count + CW'(1);
          end
        end
        KIND_DELETE: begin
          res_load = 1'b1;
          if (!del_ok) begin
            res_next.status = ST_RANGE;
          end else begin
            count_next = count - CW'(1);
          end
        end
        KIND_DUMP: begin
          res_load = (count == '0);
          res_next.status = ST_EMPTY;
        end
        default: begin
          res_load = 1'b1;
        end
      endcase
      res_next.entry_count = 5'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dumping   <= 1'b0;
      dump_idx  <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept && (cmd.kind == KIND_DUMP) && (count != '0)) begin
        dumping  <= 1'b1;
        dump_idx <= '0;
      end else if (dump_step) begin
        dump_idx <= dump_idx + CW'(1);
        if (dump_last) begin
          dumping <= 1'b0;
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
